[src/bsap_pkg.sv]
// Package for the bulk string array parser: phase, error and command codes,
// character constants, size limits and the state and result structs.
// Depends on nothing; bsap_step and the top level import it.
package bsap_pkg;

  // Size limits of one request.
  localparam int unsigned MAX_ELEMENTS      = 256;
  localparam int unsigned MAX_ELEMENT_BYTES = 16384;

  // Parser phases.
  localparam logic [2:0] PH_STAR   = 3'd0;
  localparam logic [2:0] PH_COUNT  = 3'd1;
  localparam logic [2:0] PH_DOLLAR = 3'd2;
  localparam logic [2:0] PH_LENGTH = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  // Error codes.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_STAR   = 3'd1;
  localparam logic [2:0] ERR_DOLLAR = 3'd2;
  localparam logic [2:0] ERR_COUNT  = 3'd3;
  localparam logic [2:0] ERR_LENGTH = 3'd4;

  // Input command codes.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Characters of the request syntax.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [2:0]  phase;
    logic [8:0]  count;
    logic [8:0]  index;
    logic [14:0] dlen;
    logic [14:0] flen;
    logic [2:0]  err;
  } bsap_state_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] element_index;
    logic       element_end;
    logic       command_done;
    logic [2:0] error_code;
    logic [8:0] element_count;
  } bsap_result_t;

endpackage

[src/bsap_if.sv]
// Stream interfaces of the bulk string array parser: the byte input channel
// and the result channel, each with valid/ready and its payload.
// Depends on nothing.
interface bsap_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface bsap_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [7:0] element_index;
  logic       element_end;
  logic       command_done;
  logic [2:0] error_code;
  logic [8:0] element_count;

  modport source (output valid, output data_valid, output data_byte,
                  output element_index, output element_end, output command_done,
                  output error_code, output element_count, input ready);
  modport sink   (input valid, input data_valid, input data_byte,
                  input element_index, input element_end, input command_done,
                  input error_code, input element_count, output ready);
endinterface

[src/bsap_step.sv]
// Next-state and result logic of the parser for one byte or restart beat.
// Depends on bsap_pkg.
module bsap_step (
  input  bsap_pkg::bsap_state_t  state_r,
  input  logic                   cmd,
  input  logic [7:0]             data_in,
  output bsap_pkg::bsap_state_t  state_nxt,
  output bsap_pkg::bsap_result_t result
);
  import bsap_pkg::*;

  logic        is_digit;
  logic [11:0] cnt_ext;
  logic [11:0] cnt_acc;
  logic [17:0] len_ext;
  logic [17:0] len_acc;
  logic [8:0]  idx_inc;
  logic [14:0] flen_inc;

  // Decimal accumulation: x * 10 + digit, with the digit taken from the low
  // nibble of an ASCII digit.
  assign is_digit = (data_in >= CH_ZERO) && (data_in <= CH_NINE);
  assign cnt_ext  = {3'd0, state_r.count};
  assign cnt_acc  = (cnt_ext << 3) + (cnt_ext << 1) + {8'd0, data_in[3:0]};
  assign len_ext  = {3'd0, state_r.dlen};
  assign len_acc  = (len_ext << 3) + (len_ext << 1) + {14'd0, data_in[3:0]};
  assign idx_inc  = state_r.index + 9'd1;
  assign flen_inc = state_r.flen + 15'd1;

  always_comb begin
    state_nxt = state_r;
    result    = '0;

    if (cmd == CMD_RESTART) begin
      state_nxt = '0;
      state_nxt.phase = PH_STAR;
    end else begin
      unique case (state_r.phase)
        PH_STAR: begin
          if (data_in == CH_STAR) begin
            state_nxt.phase = PH_COUNT;
          end else begin
            state_nxt.phase = PH_ERROR;
            state_nxt.err   = ERR_STAR;
          end
        end
        PH_COUNT: begin
          if (data_in == CH_LF) begin
            state_nxt.phase = (state_r.count != 9'd0) ? PH_DOLLAR : PH_DONE;
          end else if (is_digit) begin
            if (cnt_acc > 12'(MAX_ELEMENTS)) begin
              state_nxt.phase = PH_ERROR;
              state_nxt.err   = ERR_COUNT;
            end else begin
              state_nxt.count = cnt_acc[8:0];
            end
          end
        end
        PH_DOLLAR: begin
          if (data_in == CH_DOLLAR) begin
            state_nxt.phase = PH_LENGTH;
            state_nxt.dlen  = '0;
            state_nxt.flen  = '0;
          end else begin
            state_nxt.phase = PH_ERROR;
            state_nxt.err   = ERR_DOLLAR;
          end
        end
        PH_LENGTH: begin
          if (data_in == CH_LF) begin
            if (state_r.dlen != 15'd0) begin
              state_nxt.phase = PH_DATA;
            end else begin
              // An empty element closes at once with an end mark.
              result.element_end   = 1'b1;
              result.element_index = state_r.index[7:0];
              state_nxt.index      = idx_inc;
              state_nxt.phase      = (idx_inc < state_r.count) ? PH_DOLLAR : PH_DONE;
            end
          end else if (is_digit) begin
            if (len_acc > 18'(MAX_ELEMENT_BYTES)) begin
              state_nxt.phase = PH_ERROR;
              state_nxt.err   = ERR_LENGTH;
            end else begin
              state_nxt.dlen = len_acc[14:0];
            end
          end
        end
        PH_DATA: begin
          result.data_valid    = 1'b1;
          result.data_byte     = data_in;
          result.element_index = state_r.index[7:0];
          state_nxt.flen       = flen_inc;
          if (flen_inc >= state_r.dlen) begin
            result.element_end = 1'b1;
            state_nxt.index    = idx_inc;
            state_nxt.phase    = (idx_inc < state_r.count) ? PH_DOLLAR : PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
          // The error phase and any meaningless code park in the error phase.
          state_nxt.phase = PH_ERROR;
        end
      endcase
    end

    result.command_done  = (state_nxt.phase == PH_DONE);
    result.error_code    = state_nxt.err;
    result.element_count = state_nxt.count;
  end

endmodule

[src/bulk_string_array_parser_top.sv]
// Path: an accepted beat waits in the input register until the parser step
// can commit; its result is then registered in the result register.
// Throughput: one byte or restart beat per cycle unless the result stalls,
// set by the single parser step between the input and result registers.
// Reset: synchronous, active low; clears the parser state to "expect '*'"
// with zero count, index, lengths and error, and empties both registers.
// Top level of the bulk string array parser; depends on bsap_pkg, the
// interfaces in bsap_if and the step logic in bsap_step.
module bulk_string_array_parser_top (
  input logic         clk,
  input logic         rst_n,
  bsap_in_if.sink     in_bus,
  bsap_out_if.source  out_bus
);
  import bsap_pkg::*;

  // Input register stage. It holds one accepted beat until the parser step
  // can commit its result into the output register.
  logic       in_v_r;
  logic       in_cmd_r;
  logic [7:0] in_data_r;

  // Parser state and result register.
  bsap_state_t  state_r;
  bsap_state_t  state_nxt;
  bsap_result_t res_nxt;
  bsap_result_t res_r;
  logic         out_v_r;

  logic advance;
  logic in_take;

  // The step fires when there is a beat in the input register and the
  // output register is either empty or being drained in this cycle. The
  // input register frees up in the same cycle, so a new beat can enter
  // while a finished result is still waiting at the output.
  assign advance      = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  bsap_step u_step (
    .state_r   (state_r),
    .cmd       (in_cmd_r),
    .data_in   (in_data_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r  <= in_bus.cmd;
      in_data_r <= in_bus.data_in;
    end
  end

  // The parser state moves only when a step commits its result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_STAR, count: '0, index: '0, dlen: '0, flen: '0,
                   err: ERR_NONE};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.data_valid    = res_r.data_valid;
  assign out_bus.data_byte     = res_r.data_byte;
  assign out_bus.element_index = res_r.element_index;
  assign out_bus.element_end   = res_r.element_end;
  assign out_bus.command_done  = res_r.command_done;
  assign out_bus.error_code    = res_r.error_code;
  assign out_bus.element_count = res_r.element_count;

  // Payload bytes only flow while no error has been recorded.
  a_data_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.data_valid |-> res_r.error_code == ERR_NONE)
    else $error("payload byte emitted with an error recorded");

  // While elements are still expected, the index stays below the count.
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_DOLLAR || state_r.phase == PH_LENGTH ||
     state_r.phase == PH_DATA) |-> state_r.index < state_r.count)
    else $error("element index reached the declared count mid-command");

  // The declared count never exceeds the element limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {3'd0, state_r.count} <= 12'(MAX_ELEMENTS))
    else $error("declared count above the element limit");

  // Input backpressure only comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (out_v_r && !out_bus.ready))
    else $error("input stalled without a stalled result");

  // In a cycle where no step commits, the parser state holds.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("parser state moved without a committed step");

endmodule
